>>> rtl/adts_ssp_pkg.sv
`timescale 1ns / 1ps

package adts_ssp_pkg;

    // Default width of byte positions inside a probe
    localparam int unsigned POSITION_WIDTH_DEFAULT = 16;

    // Field widths
    localparam int unsigned BYTE_WIDTH     = 8;
    localparam int unsigned WINDOW_WIDTH   = 56;
    localparam int unsigned OFFSET_WIDTH   = 16;
    localparam int unsigned LENGTH_WIDTH   = 13;
    localparam int unsigned RATE_WIDTH     = 17;
    localparam int unsigned COUNT_WIDTH    = 3;
    localparam int unsigned CFG_DATA_WIDTH = 16;
    localparam int unsigned CFG_IDX_WIDTH  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WINDOW_BYTES    = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FRAMES_REQUIRED = 1'b1;

    // Configuration reset values
    localparam logic [CFG_DATA_WIDTH-1:0] WINDOW_BYTES_RESET    = 16'd8192;
    localparam logic [COUNT_WIDTH-1:0]    FRAMES_REQUIRED_RESET = 3'd3;

    // Header checks
    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
    localparam logic [7:0]  SYNC2_MASK      = 8'hF6;
    localparam logic [7:0]  SYNC2_VALUE     = 8'hF0;
    localparam logic [3:0]  RATE_INDEX_MAX  = 4'd11;
    localparam logic [12:0] MIN_FRAME_LEN   = 13'd8;
    // A header is checked once the sixth byte after its start arrives
    localparam int unsigned HEADER_SPAN     = 6;

    typedef enum logic [1:0] {
        PHASE_SEARCH = 2'd0,
        PHASE_FOLLOW = 2'd1,
        PHASE_DONE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REJECT  = 2'd2
    } verdict_t;

    typedef struct packed {
        verdict_t                  verdict;
        logic [OFFSET_WIDTH-1:0]   header_offset;
        logic [LENGTH_WIDTH-1:0]   frame_length;
        logic [RATE_WIDTH-1:0]     sample_rate;
        logic [COUNT_WIDTH-1:0]    header_count;
    } result_t;

    // Sample rate in Hz for a rate index, zero for reserved codes
    function automatic logic [RATE_WIDTH-1:0] rate_of(input logic [3:0] idx);
        logic [RATE_WIDTH-1:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/adts_ssp_core.sv
`timescale 1ns / 1ps

module adts_ssp_core
    import adts_ssp_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                      in_fire,
    input  logic [BYTE_WIDTH-1:0]     data_byte,
    input  logic                      probe_start,
    output logic                      res_valid,
    output result_t                   res
);

    localparam int unsigned PW     = POSITION_WIDTH;
    localparam int unsigned LIM_W  = ((PW > CFG_DATA_WIDTH) ? PW : CFG_DATA_WIDTH) + 1;
    localparam int unsigned NEXT_W = ((PW > LENGTH_WIDTH) ? PW : LENGTH_WIDTH) + 1;
    localparam int unsigned EXT_W  = (NEXT_W > OFFSET_WIDTH) ? NEXT_W : OFFSET_WIDTH;

    logic [CFG_DATA_WIDTH-1:0] window_bytes_reg;
    logic [COUNT_WIDTH-1:0]    frames_required_reg;

    logic [WINDOW_WIDTH-1:0]   window_reg,  window_next;
    logic [PW-1:0]             pos_reg,     pos_next;
    logic [NEXT_W-1:0]         nhp_reg,     nhp_next;
    logic [COUNT_WIDTH-1:0]    found_reg,   found_next;
    phase_t                    phase_reg,   phase_next;

    logic                      active;
    logic [NEXT_W-1:0]         nhp_eff;
    logic [COUNT_WIDTH-1:0]    found_eff;
    phase_t                    phase_eff;
    logic [LIM_W-1:0]          limit_raw;
    logic [LIM_W-1:0]          limit_cap;
    logic [LIM_W-1:0]          limit;
    logic [LIM_W-1:0]          pos_plus1;
    logic [PW-1:0]             cand;
    logic [7:0]                b0, b1, b2, b3, b4, b5;
    logic [3:0]                rate_idx;
    logic [LENGTH_WIDTH-1:0]   len;
    logic                      hdr_ok;
    logic [COUNT_WIDTH-1:0]    found_inc;
    logic [COUNT_WIDTH-1:0]    need;
    logic [EXT_W-1:0]          nhp_ext;
    logic [EXT_W-1:0]          cand_ext;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bytes_reg    <= WINDOW_BYTES_RESET;
            frames_required_reg <= FRAMES_REQUIRED_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WINDOW_BYTES:    window_bytes_reg    <= cfg_data;
                CFG_FRAMES_REQUIRED: frames_required_reg <= cfg_data[COUNT_WIDTH-1:0];
                default:             ;
            endcase
        end
    end

    // Probe state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            nhp_reg    <= '0;
            found_reg  <= '0;
            phase_reg  <= PHASE_SEARCH;
        end
        else
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            nhp_reg    <= nhp_next;
            found_reg  <= found_next;
            phase_reg  <= phase_next;
        end
    end

    // Per-word header check and state update
    always_comb
    begin
        active    = (phase_reg == PHASE_SEARCH) || (phase_reg == PHASE_FOLLOW);
        nhp_eff   = probe_start ? '0 : nhp_reg;
        found_eff = probe_start ? '0 : found_reg;
        phase_eff = probe_start ? PHASE_SEARCH : phase_reg;

        window_next = window_reg;
        pos_next    = pos_reg;
        nhp_next    = nhp_reg;
        found_next  = found_reg;
        phase_next  = phase_reg;

        // window limit, capped at the position range
        limit_raw = LIM_W'(window_bytes_reg);
        limit_cap = LIM_W'(1) << PW;
        limit     = (limit_raw > limit_cap) ? limit_cap : limit_raw;

        if (probe_start)
            pos_next = '0;
        else
            pos_next = pos_reg + PW'(1);
        window_next = {(probe_start ? 48'd0 : window_reg[47:0]), data_byte};
        pos_plus1   = LIM_W'(pos_next) + LIM_W'(1);
        cand        = pos_next - PW'(HEADER_SPAN);

        // header fields from the oldest six bytes
        b0 = window_next[55:48];
        b1 = window_next[47:40];
        b2 = window_next[39:32];
        b3 = window_next[31:24];
        b4 = window_next[23:16];
        b5 = window_next[15:8];
        rate_idx = b2[5:2];
        len      = {b3[1:0], b4, b5[7:5]};
        hdr_ok   = (b0 == SYNC_BYTE) && ((b1 & SYNC2_MASK) == SYNC2_VALUE) &&
                   (rate_idx <= RATE_INDEX_MAX) && (len >= MIN_FRAME_LEN);

        found_inc = found_eff + COUNT_WIDTH'(1);
        need      = (frames_required_reg == '0) ? COUNT_WIDTH'(1) : frames_required_reg;
        nhp_ext   = EXT_W'(nhp_eff);
        cand_ext  = EXT_W'(cand);

        res_valid         = 1'b0;
        res.verdict       = VERDICT_REJECT;
        res.header_offset = cand_ext[OFFSET_WIDTH-1:0];
        res.frame_length  = len;
        res.sample_rate   = rate_of(rate_idx);
        res.header_count  = found_eff;

        if (!in_fire || (!probe_start && !active))
        begin
            // nothing taken, or verdict already given: state holds
            window_next = window_reg;
            pos_next    = pos_reg;
        end
        else
        begin
            nhp_next   = nhp_eff;
            found_next = found_eff;
            phase_next = phase_eff;
            if (pos_plus1 >= limit)
            begin
                // window exhausted
                phase_next        = PHASE_DONE;
                res_valid         = 1'b1;
                res.header_offset = nhp_ext[OFFSET_WIDTH-1:0];
                res.frame_length  = '0;
                res.sample_rate   = '0;
            end
            else if (pos_next < PW'(HEADER_SPAN))
            begin
                // header not complete yet
            end
            else if ((phase_eff == PHASE_FOLLOW) && (NEXT_W'(cand) != nhp_eff))
            begin
                // not at the expected header start
            end
            else if (!hdr_ok)
            begin
                if (phase_eff == PHASE_FOLLOW)
                begin
                    phase_next = PHASE_DONE;
                    res_valid  = 1'b1;
                end
            end
            else
            begin
                found_next       = found_inc;
                nhp_next         = NEXT_W'(cand) + NEXT_W'(len);
                res_valid        = 1'b1;
                res.header_count = found_inc;
                if (found_inc >= need)
                begin
                    phase_next  = PHASE_DONE;
                    res.verdict = VERDICT_ACCEPT;
                end
                else
                begin
                    phase_next  = PHASE_FOLLOW;
                    res.verdict = VERDICT_PENDING;
                end
            end
        end
    end

endmodule

>>> rtl/adts_ssp_out_buf.sv
`timescale 1ns / 1ps

module adts_ssp_out_buf
    import adts_ssp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic [1:0] count_reg,  count_next;
    result_t    head_reg,   head_next;
    result_t    skid_reg,   skid_next;
    logic       pop;

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // Two-entry queue: head drives the port, skid absorbs one extra word
    always_comb
    begin
        pop        = out_valid && !out_stall;
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        if (pop && push)
        begin
            if (count_reg == 2'd2)
            begin
                head_next = skid_reg;
                skid_next = push_data;
            end
            else
                head_next = push_data;
        end
        else if (pop)
        begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_next = push_data;
            else
                skid_next = push_data;
            count_next = count_reg + 2'd1;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = head_reg;

endmodule

>>> rtl/adts_stream_sync_probe.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  data_byte, probe_start
// output   out        out_valid/out_stall verdict, header_offset, frame_length,
//                                        sample_rate, header_count
// config   in         cfg_wr_en          cfg_index, cfg_data
//
// One byte word is taken every cycle unless the input is stalled; its result,
// if any, is registered in the output queue and reaches the output port once
// the words ahead of it are taken. The state update is a single pass through
// the header check logic, so the rate is one word per clock when not stalled.
// A two-entry output queue stalls the input only when both entries hold words
// the output has not taken. Reset restores config defaults and probe state.

module adts_stream_sync_probe
    import adts_ssp_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [BYTE_WIDTH-1:0]     data_byte,
    input  logic                      probe_start,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                verdict,
    output logic [OFFSET_WIDTH-1:0]   header_offset,
    output logic [LENGTH_WIDTH-1:0]   frame_length,
    output logic [RATE_WIDTH-1:0]     sample_rate,
    output logic [COUNT_WIDTH-1:0]    header_count
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    full;

    assign in_stall = full;
    assign in_fire  = in_valid && !full;

    // Header search and state
    adts_ssp_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .data_byte   (data_byte),
        .probe_start (probe_start),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register with skid entry
    adts_ssp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign verdict       = out_data.verdict;
    assign header_offset = out_data.header_offset;
    assign frame_length  = out_data.frame_length;
    assign sample_rate   = out_data.sample_rate;
    assign header_count  = out_data.header_count;

endmodule
